/* sv/html_entity_decoder_unit_defines.svh */
// assertion macros for the entity decoder checker
`ifndef HTML_ENTITY_DECODER_UNIT_DEFINES_SVH
`define HTML_ENTITY_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define HED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define HED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/hed_pkg.sv */
// shared constants, entity tables and types of the entity decoder
`timescale 1ns / 1ps

package hed_pkg;

    localparam int HOLD_DEPTH = 5;
    localparam int RES_MAX    = HOLD_DEPTH + 1;
    localparam int ENT_NUM    = 6;
    localparam int ENT_MAXLEN = 6;
    localparam int CNT_W      = 3;

    localparam logic [7:0] AMP = 8'h26;

    // entity spellings, unused tail chars are zero
    localparam logic [7:0] ENT_TEXT [ENT_NUM][ENT_MAXLEN] = '{
        '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},   // &lt;
        '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},   // &gt;
        '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},   // &amp;
        '{8'h26, 8'h6e, 8'h62, 8'h73, 8'h70, 8'h3b},   // &nbsp;
        '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},   // &quot;
        '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b}    // &apos;
    };

    localparam logic [CNT_W-1:0] ENT_LEN [ENT_NUM] = '{
        3'd4, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6
    };

    localparam logic [7:0] ENT_REPL [ENT_NUM] = '{
        8'h3c, 8'h3e, 8'h26, 8'h20, 8'h22, 8'h27
    };

    // result bytes produced by one item, slot 0 goes out first
    typedef struct packed {
        logic [RES_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } hed_batch_t;

endpackage

/* sv/hed_matcher.sv */
// entity matcher: held prefix state and per-item result batch
`timescale 1ns / 1ps

module hed_matcher
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         in_byte,
    input  logic               is_last,
    output hed_pkg::hed_batch_t batch
);
    import hed_pkg::*;

    logic [7:0]       held_reg [HOLD_DEPTH];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [7:0]       cand [RES_MAX];
    logic [CNT_W-1:0] n;
    logic             full;
    logic             partial;
    logic             ok;
    logic [7:0]       repl;

    always_comb
    begin
        for (int j = 0; j < HOLD_DEPTH; j++)
        begin
            cand[j] = (CNT_W'(j) < cnt_reg) ? held_reg[j] : in_byte;
        end
        cand[HOLD_DEPTH] = in_byte;
        n       = cnt_reg + 3'd1;
        full    = 1'b0;
        partial = 1'b0;
        repl    = 8'h00;
        ok      = 1'b0;
        for (int i = 0; i < ENT_NUM; i++)
        begin
            ok = (n <= ENT_LEN[i]);
            for (int j = 0; j < ENT_MAXLEN; j++)
            begin
                if (CNT_W'(j) < n && ENT_TEXT[i][j] != cand[j])
                begin
                    ok = 1'b0;
                end
            end
            if (ok && n == ENT_LEN[i])
            begin
                full = 1'b1;
                repl = ENT_REPL[i];
            end
            if (ok && n < ENT_LEN[i])
            begin
                partial = 1'b1;
            end
        end
    end

    // results are always the held bytes followed by the new byte, or one replacement
    always_comb
    begin
        for (int k = 0; k < HOLD_DEPTH; k++)
        begin
            batch.bytes[k] = (CNT_W'(k) < cnt_reg) ? held_reg[k] : in_byte;
        end
        batch.bytes[HOLD_DEPTH] = in_byte;
        batch.last = is_last;
        if (full)
        begin
            batch.bytes[0] = repl;
            batch.count    = 3'd1;
            cnt_next       = '0;
        end
        else if (partial)
        begin
            batch.count = is_last ? n : '0;
            cnt_next    = is_last ? '0 : n;
        end
        else
        begin
            batch.count = cnt_reg + CNT_W'(in_byte != AMP || is_last);
            cnt_next    = (in_byte == AMP && !is_last) ? 3'd1 : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (step)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // held bytes carry no reset, only entries below the count are read
    always_ff @(posedge clk)
    begin
        if (step && partial && !full && !is_last)
        begin
            held_reg[cnt_reg] <= in_byte;
        end
        else if (step && !full && !partial && in_byte == AMP && !is_last)
        begin
            held_reg[0] <= in_byte;
        end
    end

endmodule

/* sv/hed_emitter.sv */
// result buffer that shifts out one decoded byte per handshake
`timescale 1ns / 1ps

module hed_emitter
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  hed_pkg::hed_batch_t batch,
    output logic               can_load,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // out_byte
    output logic               m_axis_tlast,   // run_last
    output logic [0:0]         m_axis_tuser    // text_end
);
    import hed_pkg::*;

    logic [RES_MAX-1:0][7:0] buf_reg;
    logic [RES_MAX-1:0][7:0] buf_next;
    logic [CNT_W-1:0]        left_reg;
    logic [CNT_W-1:0]        left_next;
    logic                    end_reg;
    logic                    end_next;
    logic                    take;

    assign take          = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (left_reg != '0);
    assign m_axis_tdata  = buf_reg[0];
    assign m_axis_tlast  = (left_reg == 3'd1);
    assign m_axis_tuser  = m_axis_tlast && end_reg;
    // free when empty, or once the final pending byte leaves this cycle
    assign can_load      = (left_reg == '0) || (left_reg == 3'd1 && m_axis_tready);

    always_comb
    begin
        buf_next  = buf_reg;
        left_next = left_reg;
        end_next  = end_reg;
        if (load)
        begin
            buf_next  = batch.bytes;
            left_next = batch.count;
            end_next  = batch.last;
        end
        else if (take)
        begin
            for (int k = 0; k < RES_MAX - 1; k++)
            begin
                buf_next[k] = buf_reg[k + 1];
            end
            left_next = left_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            end_reg  <= 1'b0;
        end
        else
        begin
            left_reg <= left_next;
            end_reg  <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

/* sv/html_entity_decoder_unit.sv */
// Streaming HTML entity decoder, top level.
// Each input byte is registered, then its results are loaded into the result buffer that drives the output.
// Throughput: one item per cycle while each item yields at most one byte and the output is ready;
// an item yielding more than one byte holds the result buffer until its last byte is taken.
// Reset clears the held prefix count, the input valid flag and the result buffer count; byte storage has no reset.
`timescale 1ns / 1ps

module html_entity_decoder_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // in_byte
    input  logic       s_axis_tlast,    // is_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // out_byte
    output logic       m_axis_tlast,    // run_last
    output logic [0:0] m_axis_tuser     // text_end
);
    import hed_pkg::*;

    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       can_load;
    logic       load;
    hed_batch_t batch;

    assign load          = in_vld_reg && can_load;
    assign s_axis_tready = !in_vld_reg || load;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_vld_next = 1'b1;
        end
        else if (load)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    hed_matcher u_matcher
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (load),
        .in_byte (in_byte_reg),
        .is_last (in_last_reg),
        .batch   (batch)
    );

    hed_emitter u_emitter
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .batch         (batch),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* sv/hed_checker.sv */
// port-level checks on the entity decoder, bound to the top level
`timescale 1ns / 1ps
`include "html_entity_decoder_unit_defines.svh"

module hed_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [0:0] m_axis_tuser
);

    logic        end_beat;
    logic        in_stall;
    logic        out_stall;
    logic [10:0] out_now;

    assign end_beat  = m_axis_tvalid && m_axis_tuser[0];
    assign in_stall  = !s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    // valid is part of the snapshot so a held item also stays valid
    assign out_now   = {m_axis_tvalid, m_axis_tuser, m_axis_tlast, m_axis_tdata};

    // end of text only on the closing byte of an item
    `HED_ASSERT_NOW(a_end_on_last, clk, rst_n, end_beat, m_axis_tlast, "end without run last")

    // input side only stalls while results are pending
    `HED_ASSERT_NOW(a_stall_has_output, clk, rst_n, in_stall, m_axis_tvalid, "stall, no output")

    // a stalled result holds
    `HED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, $stable(out_now), "stalled item changed")

endmodule

bind html_entity_decoder_unit hed_checker u_hed_checker (.*);
